### design/olu_pkg.sv
// Shared types, widths and defaults for the occupancy ray log-odds updater.
// No dependencies; compiled first.
package olu_pkg;

    localparam int GRID_WIDTH_DEF  = 256;
    localparam int GRID_HEIGHT_DEF = 256;

    localparam int CELL_W     = 8;
    localparam int COORD_W    = 16;
    localparam int GRID_IDX_W = 8;
    localparam int TOUCH_W    = 17;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    // Bresenham error term: holds +/- twice the largest span with margin
    localparam int ERR_W = COORD_W + 4;

    localparam logic signed [CELL_W-1:0] MISS_WEIGHT_RST = -8'sd4;
    localparam logic signed [CELL_W-1:0] HIT_WEIGHT_RST  = 8'sd9;
    localparam logic signed [CELL_W-1:0] CLAMP_LOW_RST   = -8'sd100;
    localparam logic signed [CELL_W-1:0] CLAMP_HIGH_RST  = 8'sd100;

    typedef enum logic [1:0] {
        MODE_RAY   = 2'd0,
        MODE_READ  = 2'd1,
        MODE_CLEAR = 2'd2,
        MODE_NONE  = 2'd3
    } t_mode;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MISS_WEIGHT = 2'd0,
        CFG_HIT_WEIGHT  = 2'd1,
        CFG_CLAMP_LOW   = 2'd2,
        CFG_CLAMP_HIGH  = 2'd3
    } t_cfg_reg;

    typedef struct packed {
        logic at_end;
        logic in_grid;
    } t_walk_stat;

endpackage

### design/olu_if.sv
// Ray/read/clear item channel and result channel (valid/ready beats).
// Depends on olu_pkg.
interface olu_in_if;
    logic                                 valid;
    logic                                 ready;
    logic [1:0]                           mode;
    logic signed [olu_pkg::COORD_W-1:0]   start_x;
    logic signed [olu_pkg::COORD_W-1:0]   start_y;
    logic signed [olu_pkg::COORD_W-1:0]   end_x;
    logic signed [olu_pkg::COORD_W-1:0]   end_y;
    logic                                 has_hit;
    logic [olu_pkg::GRID_IDX_W-1:0]       cell_x;
    logic [olu_pkg::GRID_IDX_W-1:0]       cell_y;

    modport source (output valid, mode, start_x, start_y, end_x, end_y, has_hit,
                    cell_x, cell_y, input ready);
    modport sink   (input valid, mode, start_x, start_y, end_x, end_y, has_hit,
                    cell_x, cell_y, output ready);
endinterface

interface olu_out_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [olu_pkg::CELL_W-1:0]    cell_value;
    logic [olu_pkg::TOUCH_W-1:0]          cells_touched;

    modport source (output valid, cell_value, cells_touched, input ready);
    modport sink   (input valid, cell_value, cells_touched, output ready);
endinterface

### design/olu_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module olu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

### design/olu_cell_alu.sv
// Shared cell update unit: add a weight to a log-odds cell, then clamp.
// Depends on olu_pkg.
module olu_cell_alu (
    input  logic signed [olu_pkg::CELL_W-1:0] i_cell,
    input  logic signed [olu_pkg::CELL_W-1:0] i_weight,
    input  logic signed [olu_pkg::CELL_W-1:0] i_clamp_low,
    input  logic signed [olu_pkg::CELL_W-1:0] i_clamp_high,
    output logic signed [olu_pkg::CELL_W-1:0] o_cell
);
    import olu_pkg::*;

    logic signed [CELL_W:0] sum;
    logic signed [CELL_W:0] upper;

    always_comb begin
        sum = (CELL_W+1)'(i_cell) + (CELL_W+1)'(i_weight);
        // high bound first, then low bound; inverted bounds give clamp_low
        upper = (sum > (CELL_W+1)'(i_clamp_high)) ? (CELL_W+1)'(i_clamp_high) : sum;
        if (upper < (CELL_W+1)'(i_clamp_low)) begin
            o_cell = i_clamp_low;
        end else begin
            o_cell = upper[CELL_W-1:0];
        end
    end
endmodule

### design/olu_line_step.sv
// Bresenham line walker: one cell step per i_step, grid bounds and address.
// Depends on olu_pkg.
module olu_line_step #(
    parameter int GRID_WIDTH  = olu_pkg::GRID_WIDTH_DEF,
    parameter int GRID_HEIGHT = olu_pkg::GRID_HEIGHT_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_load,
    input  logic                                i_step,
    input  logic signed [olu_pkg::COORD_W-1:0]  i_start_x,
    input  logic signed [olu_pkg::COORD_W-1:0]  i_start_y,
    input  logic signed [olu_pkg::COORD_W-1:0]  i_end_x,
    input  logic signed [olu_pkg::COORD_W-1:0]  i_end_y,
    output olu_pkg::t_walk_stat                 o_stat,
    output logic [$clog2(GRID_WIDTH)+$clog2(GRID_HEIGHT)-1:0] o_addr
);
    import olu_pkg::*;

    localparam int XW = $clog2(GRID_WIDTH);
    localparam int YW = $clog2(GRID_HEIGHT);
    localparam int SPAN_W = COORD_W + 1;
    localparam logic signed [COORD_W-1:0] X_LIM = COORD_W'(GRID_WIDTH);
    localparam logic signed [COORD_W-1:0] Y_LIM = COORD_W'(GRID_HEIGHT);

    logic signed [COORD_W-1:0] r_cx, r_cy, r_x1, r_y1;
    logic [SPAN_W-1:0]         r_dx, r_dy;
    logic                      r_sx_neg, r_sy_neg;
    logic signed [ERR_W-1:0]   r_err;

    logic signed [SPAN_W-1:0]  dxs, dys;
    logic [SPAN_W-1:0]         n_dx, n_dy;
    logic signed [ERR_W:0]     e2, dx_e, dy_e;
    logic                      step_x, step_y;
    logic signed [ERR_W-1:0]   n_err;

    always_comb begin
        dxs  = SPAN_W'(i_end_x) - SPAN_W'(i_start_x);
        dys  = SPAN_W'(i_end_y) - SPAN_W'(i_start_y);
        n_dx = dxs[SPAN_W-1] ? SPAN_W'(-dxs) : dxs;
        n_dy = dys[SPAN_W-1] ? SPAN_W'(-dys) : dys;

        e2     = {r_err, 1'b0};
        dx_e   = (ERR_W+1)'(r_dx);
        dy_e   = (ERR_W+1)'(r_dy);
        step_x = e2 > -dy_e;
        step_y = e2 < dx_e;
        n_err  = r_err - (step_x ? ERR_W'(r_dy) : '0) + (step_y ? ERR_W'(r_dx) : '0);
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_cx     <= i_start_x;
            r_cy     <= i_start_y;
            r_x1     <= i_end_x;
            r_y1     <= i_end_y;
            r_dx     <= n_dx;
            r_dy     <= n_dy;
            r_sx_neg <= dxs[SPAN_W-1] || (dxs == '0);
            r_sy_neg <= dys[SPAN_W-1] || (dys == '0);
            r_err    <= ERR_W'(n_dx) - ERR_W'(n_dy);
        end else if (i_step) begin
            r_err <= n_err;
            if (step_x) begin
                r_cx <= r_cx + (r_sx_neg ? -16'sd1 : 16'sd1);
            end
            if (step_y) begin
                r_cy <= r_cy + (r_sy_neg ? -16'sd1 : 16'sd1);
            end
        end
    end

    assign o_stat.at_end  = (r_cx == r_x1) && (r_cy == r_y1);
    assign o_stat.in_grid = !r_cx[COORD_W-1] && (r_cx < X_LIM) &&
                            !r_cy[COORD_W-1] && (r_cy < Y_LIM);
    assign o_addr = {r_cy[YW-1:0], r_cx[XW-1:0]};
endmodule

### design/occupancy_ray_log_odds_update.sv
// Top level of the occupancy grid log-odds ray updater: sequencer, config
// registers, grid RAM. Depends on olu_pkg, olu_if, olu_ram, olu_cell_alu,
// olu_line_step.
//
// Usage
//   i_in  : one beat per item. mode RAY walks start->end (end excluded),
//           adding miss_weight to each in-grid cell, then hit_weight to the
//           end cell when has_hit is set and it lies in the grid. mode READ
//           returns one cell, mode CLEAR zeroes the grid, the spare code
//           only returns zeros.
//   o_out : exactly one beat per item (cell_value, cells_touched).
//   cfg   : i_cfg_we/i_cfg_index/i_cfg_data; the user writes only while idle.
// Sequencing
//   One item at a time. A ray steps over a path cell outside the grid in S_WALK
//   alone; an in-grid cell takes a RAM read in S_WALK, then add/clamp and write
//   back in the shared cell unit in S_MISS; a hit adds S_HIT before S_DONE.
//   In-grid reads wait in S_RDWAIT; off-grid reads and spare go to S_DONE. A clear
//   sweeps every RAM address, 2^(clog2(W)+clog2(H)) of them (65536 at 256x256).
// Reset
//   Config returns to defaults and the same sweep zeroes the grid; i_in is
//   not ready until it ends. Config writes are taken throughout.
// Stall
//   Results sit in an output register; i_in takes the next item while one
//   waits, and a finished item holds until the register frees up.
module occupancy_ray_log_odds_update #(
    parameter int GRID_WIDTH  = olu_pkg::GRID_WIDTH_DEF,
    parameter int GRID_HEIGHT = olu_pkg::GRID_HEIGHT_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    olu_in_if.sink                               i_in,
    olu_out_if.source                            o_out,
    input  logic                                 i_cfg_we,
    input  logic [olu_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [olu_pkg::CFG_DATA_W-1:0]       i_cfg_data
);
    import olu_pkg::*;

    localparam int XW = $clog2(GRID_WIDTH);
    localparam int YW = $clog2(GRID_HEIGHT);
    localparam int AW = XW + YW;
    localparam int RAM_DEPTH = 1 << AW;
    localparam logic signed [COORD_W-1:0] X_LIM = COORD_W'(GRID_WIDTH);
    localparam logic signed [COORD_W-1:0] Y_LIM = COORD_W'(GRID_HEIGHT);

    typedef enum logic [2:0] {
        S_CLEAR,   // zero sweep over the RAM
        S_IDLE,    // waiting for an item
        S_RDWAIT,  // read mode: RAM data arriving
        S_WALK,    // ray: look at current cell, step walker
        S_MISS,    // ray: write back free cell
        S_HIT,     // ray: write back end cell
        S_DONE     // hand result to output register
    } t_state;

    t_state r_state, n_state;

    // config
    logic signed [CELL_W-1:0] r_miss_w, r_hit_w, r_clamp_lo, r_clamp_hi;

    // item bookkeeping
    logic [AW-1:0]            r_clr_addr;
    logic                     r_clr_reply;
    logic                     r_hit;
    logic [AW-1:0]            r_wr_addr;
    logic [TOUCH_W-1:0]       r_touched;
    logic signed [CELL_W-1:0] r_value;

    // output register
    logic                     r_out_valid;
    logic signed [CELL_W-1:0] r_out_value;
    logic [TOUCH_W-1:0]       r_out_touched;

    // datapath
    logic                     in_fire;
    t_mode                    in_mode;
    logic signed [COORD_W-1:0] rd_x, rd_y;
    logic                     rd_inside;
    logic [AW-1:0]            rd_addr;
    t_walk_stat               walk_stat;
    logic [AW-1:0]            walk_addr;
    logic                     walk_load, walk_step;
    logic                     ram_we;
    logic [AW-1:0]            ram_waddr, ram_raddr;
    logic [CELL_W-1:0]        ram_wdata, ram_rdata;
    logic signed [CELL_W-1:0] alu_weight, alu_out;
    logic                     out_load;

    assign in_fire = i_in.valid && i_in.ready;
    assign in_mode = t_mode'(i_in.mode);

    // read-mode address; cell_x/cell_y are unsigned, so zero-extend
    assign rd_x      = COORD_W'(i_in.cell_x);
    assign rd_y      = COORD_W'(i_in.cell_y);
    assign rd_inside = (rd_x < X_LIM) && (rd_y < Y_LIM);
    assign rd_addr   = {rd_y[YW-1:0], rd_x[XW-1:0]};

    olu_line_step #(
        .GRID_WIDTH  (GRID_WIDTH),
        .GRID_HEIGHT (GRID_HEIGHT)
    ) u_walk (
        .i_clk     (i_clk),
        .i_load    (walk_load),
        .i_step    (walk_step),
        .i_start_x (i_in.start_x),
        .i_start_y (i_in.start_y),
        .i_end_x   (i_in.end_x),
        .i_end_y   (i_in.end_y),
        .o_stat    (walk_stat),
        .o_addr    (walk_addr)
    );

    // one add/clamp unit serves both free cells and the hit cell
    assign alu_weight = (r_state == S_HIT) ? r_hit_w : r_miss_w;

    olu_cell_alu u_alu (
        .i_cell       (signed'(ram_rdata)),
        .i_weight     (alu_weight),
        .i_clamp_low  (r_clamp_lo),
        .i_clamp_high (r_clamp_hi),
        .o_cell       (alu_out)
    );

    olu_ram #(
        .WIDTH (CELL_W),
        .DEPTH (RAM_DEPTH)
    ) u_grid (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // sequencer
    always_comb begin
        n_state   = r_state;
        ram_we    = 1'b0;
        ram_waddr = r_wr_addr;
        ram_wdata = alu_out;
        ram_raddr = walk_addr;
        walk_load = 1'b0;
        walk_step = 1'b0;
        out_load  = 1'b0;
        case (r_state)
            S_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_clr_addr;
                ram_wdata = '0;
                if (&r_clr_addr) begin
                    n_state = r_clr_reply ? S_DONE : S_IDLE;
                end
            end
            S_IDLE: begin
                ram_raddr = rd_addr;
                if (in_fire) begin
                    case (in_mode)
                        MODE_RAY: begin
                            walk_load = 1'b1;
                            n_state   = S_WALK;
                        end
                        MODE_READ:  n_state = rd_inside ? S_RDWAIT : S_DONE;
                        MODE_CLEAR: n_state = S_CLEAR;
                        default:    n_state = S_DONE;
                    endcase
                end
            end
            S_RDWAIT: n_state = S_DONE;
            S_WALK: begin
                if (walk_stat.at_end) begin
                    n_state = (r_hit && walk_stat.in_grid) ? S_HIT : S_DONE;
                end else begin
                    // read issued at the current cell while the walker moves on
                    walk_step = 1'b1;
                    if (walk_stat.in_grid) begin
                        n_state = S_MISS;
                    end
                end
            end
            S_MISS: begin
                ram_we  = 1'b1;
                n_state = S_WALK;
            end
            S_HIT: begin
                ram_we  = 1'b1;
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || o_out.ready) begin
                    out_load = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_clr_reply <= 1'b0;
            r_out_valid <= 1'b0;
            r_miss_w    <= MISS_WEIGHT_RST;
            r_hit_w     <= HIT_WEIGHT_RST;
            r_clamp_lo  <= CLAMP_LOW_RST;
            r_clamp_hi  <= CLAMP_HIGH_RST;
        end else begin
            r_state <= n_state;

            if (i_cfg_we) begin
                case (t_cfg_reg'(i_cfg_index))
                    CFG_MISS_WEIGHT: r_miss_w   <= signed'(i_cfg_data);
                    CFG_HIT_WEIGHT:  r_hit_w    <= signed'(i_cfg_data);
                    CFG_CLAMP_LOW:   r_clamp_lo <= signed'(i_cfg_data);
                    CFG_CLAMP_HIGH:  r_clamp_hi <= signed'(i_cfg_data);
                    default: ;
                endcase
            end

            if (r_state == S_CLEAR) begin
                r_clr_addr <= r_clr_addr + 1'b1;  // wraps back to zero at the end
            end

            if (in_fire) begin
                r_clr_reply <= (in_mode == MODE_CLEAR);
                r_hit       <= i_in.has_hit;
                r_touched   <= '0;
                r_value     <= '0;
            end

            if (r_state == S_RDWAIT) begin
                r_value <= signed'(ram_rdata);
            end

            if (r_state == S_WALK) begin
                r_wr_addr <= walk_addr;
            end

            if (ram_we && r_state != S_CLEAR && !(&r_touched)) begin
                r_touched <= r_touched + 1'b1;
            end

            if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            if (out_load) begin
                r_out_valid   <= 1'b1;
                r_out_value   <= r_value;
                r_out_touched <= r_touched;
            end
        end
    end

    assign i_in.ready          = (r_state == S_IDLE);
    assign o_out.valid         = r_out_valid;
    assign o_out.cell_value    = r_out_value;
    assign o_out.cells_touched = r_out_touched;

    // grid is only written by the sweep or by a ray write-back
    a_ram_write_owner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> (r_state == S_CLEAR || r_state == S_MISS || r_state == S_HIT))
        else $error("grid write outside sweep or write-back");

    // a new result only appears when the sequencer hands one over
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out.valid) |-> $past(r_state == S_DONE))
        else $error("result beat without a finished item");

    // a free-cell write-back always follows a walk step at an in-grid cell
    a_miss_after_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MISS) |-> ($past(r_state == S_WALK) && $past(walk_step)
                                 && $past(walk_stat.in_grid)))
        else $error("write-back without an in-grid walk step");
endmodule

### tb/tb_occupancy_ray_log_odds_update.sv
`timescale 1ns / 1ps
// Self-checking bench for occupancy_ray_log_odds_update: directed rows then random rays, reads, clears, spares.
// Depends on olu_pkg, the olu_in_if / olu_out_if channel interfaces and the top level.
module tb_occupancy_ray_log_odds_update;
    import olu_pkg::*;

    localparam int GRID_W    = GRID_WIDTH_DEF;
    localparam int GRID_H    = GRID_HEIGHT_DEF;
    localparam int TOUCH_SAT = (1 << TOUCH_W) - 1;

    // one item beat as the bench sees it
    typedef struct packed {
        t_mode                     mode;
        logic signed [COORD_W-1:0] start_x, start_y, end_x, end_y;
        logic                      has_hit;
        logic [GRID_IDX_W-1:0]     cell_x, cell_y;
    } olu_beat_t;

    typedef struct packed {
        logic signed [CELL_W-1:0] cell_value;
        logic [TOUCH_W-1:0]       cells_touched;
    } olu_result_t;

    // directed row: either a full config load or one beat, with an optional
    // hand-typed expectation that replaces the predicted one
    typedef struct packed {
        logic                     is_cfg;
        logic signed [CELL_W-1:0] miss_w, hit_w, lo_w, hi_w;
        olu_beat_t                beat;
        logic                     fixed;
        olu_result_t              want;
    } dir_row_t;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    logic                  i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;
    logic                  rx_ready    = 1'b0;

    olu_in_if  in_ch  ();
    olu_out_if out_ch ();

    assign out_ch.ready = rx_ready;

    occupancy_ray_log_odds_update #(
        .GRID_WIDTH  (GRID_W),
        .GRID_HEIGHT (GRID_H)
    ) u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (in_ch),
        .o_out       (out_ch),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Grid model: own copy of the cells and the four registers.
    // Cells stored row major, index = y * GRID_W + x.
    // ------------------------------------------------------------------
    logic signed [CELL_W-1:0] grid_model [GRID_W*GRID_H];
    int miss_m = int'(MISS_WEIGHT_RST);
    int hit_m  = int'(HIT_WEIGHT_RST);
    int lo_m   = int'(CLAMP_LOW_RST);
    int hi_m   = int'(CLAMP_HIGH_RST);

    olu_result_t pending_results [$];
    int          fail_count    = 0;
    int          send_gap_pct  = 0;
    int          stall_pct     = 0;
    // last in-grid ray end, else start; most random reads aim there
    int          last_x        = 0;
    int          last_y        = 0;

    function automatic bit in_grid(int x, int y);
        return x >= 0 && y >= 0 && x < GRID_W && y < GRID_H;
    endfunction

    // add a weight, then limit to the top bound and raise to the bottom one;
    // with an inverted pair the bottom bound wins
    function automatic void bump_cell(int x, int y, int w);
        int idx, v;
        idx = y * GRID_W + x;
        v   = int'(grid_model[idx]) + w;
        if (v > hi_m) v = hi_m;
        if (v < lo_m) v = lo_m;
        grid_model[idx] = v[CELL_W-1:0];
    endfunction

    // applies one item to the grid model and returns the result beat it makes
    function automatic olu_result_t advance_grid_model(olu_beat_t b);
        olu_result_t r;
        int x0, y0, x1, y1, dx, dy, sx, sy, err, e2, cx, cy;
        r = '0;
        case (b.mode)
            MODE_RAY: begin
                x0  = int'($signed(b.start_x));
                y0  = int'($signed(b.start_y));
                x1  = int'($signed(b.end_x));
                y1  = int'($signed(b.end_y));
                dx  = (x1 > x0) ? x1 - x0 : x0 - x1;
                dy  = (y1 > y0) ? y1 - y0 : y0 - y1;
                sx  = (x0 < x1) ? 1 : -1;
                sy  = (y0 < y1) ? 1 : -1;
                err = dx - dy;
                cx  = x0;
                cy  = y0;
                // Bresenham walk, end cell excluded
                while (cx != x1 || cy != y1) begin
                    if (in_grid(cx, cy)) begin
                        bump_cell(cx, cy, miss_m);
                        if (r.cells_touched != TOUCH_SAT) r.cells_touched++;
                    end
                    e2 = 2 * err;
                    if (e2 > -dy) begin
                        err -= dy;
                        cx  += sx;
                    end
                    if (e2 < dx) begin
                        err += dx;
                        cy  += sy;
                    end
                end
                if (b.has_hit && in_grid(x1, y1)) begin
                    bump_cell(x1, y1, hit_m);
                    if (r.cells_touched != TOUCH_SAT) r.cells_touched++;
                end
            end
            MODE_READ: begin
                if (in_grid(int'(b.cell_x), int'(b.cell_y)))
                    r.cell_value = grid_model[int'(b.cell_y) * GRID_W + int'(b.cell_x)];
            end
            MODE_CLEAR: begin
                foreach (grid_model[i]) grid_model[i] = '0;
            end
            default: ;  // spare code: no effect, zero result
        endcase
        return r;
    endfunction

    function automatic void note_failure(string msg);
        if (fail_count < 10) $display("%s", msg);
        fail_count++;
    endfunction

    // ------------------------------------------------------------------
    // Directed row builders
    // ------------------------------------------------------------------
    function automatic dir_row_t ray_row(int sx, int sy, int ex, int ey, bit hit,
                                         bit fixed, int touched);
        dir_row_t row;
        row                    = '0;
        row.beat.mode          = MODE_RAY;
        row.beat.start_x       = 16'(sx);
        row.beat.start_y       = 16'(sy);
        row.beat.end_x         = 16'(ex);
        row.beat.end_y         = 16'(ey);
        row.beat.has_hit       = hit;
        row.beat.cell_x        = 8'hA5;   // ignored on a ray
        row.beat.cell_y        = 8'h5A;
        row.fixed              = fixed;
        row.want.cells_touched = TOUCH_W'(touched);
        return row;
    endfunction

    function automatic dir_row_t read_row(int cx, int cy, bit fixed, int value);
        dir_row_t row;
        row                 = '0;
        row.beat.mode       = MODE_READ;
        row.beat.start_x    = 16'sh7FFF;  // ray fields ignored on a read
        row.beat.end_y      = 16'sh8000;
        row.beat.has_hit    = 1'b1;
        row.beat.cell_x     = 8'(cx);
        row.beat.cell_y     = 8'(cy);
        row.fixed           = fixed;
        row.want.cell_value = 8'(value);
        return row;
    endfunction

    // clear and spare code: both always answer zeros
    function automatic dir_row_t cmd_row(t_mode m);
        dir_row_t row;
        row              = '0;
        row.beat.mode    = m;
        row.beat.start_x = 16'sh0003;
        row.beat.start_y = 16'sh0003;
        row.beat.end_x   = 16'sh0040;
        row.beat.end_y   = 16'sh0020;
        row.beat.has_hit = 1'b1;
        row.beat.cell_x  = 8'd3;
        row.beat.cell_y  = 8'd3;
        row.fixed        = 1'b1;
        return row;
    endfunction

    function automatic dir_row_t cfg_row(int miss, int hit, int lo, int hi);
        dir_row_t row;
        row        = '0;
        row.is_cfg = 1'b1;
        row.miss_w = 8'(miss);
        row.hit_w  = 8'(hit);
        row.lo_w   = 8'(lo);
        row.hi_w   = 8'(hi);
        return row;
    endfunction

    function automatic int sat16(int v);
        if (v > 32767)  return 32767;
        if (v < -32768) return -32768;
        return v;
    endfunction

    // ------------------------------------------------------------------
    // Random item: mostly short rays near one corner so cells pile up and
    // saturate, some rays crossing the grid edges, a few far outside the
    // grid (full 16-bit coordinates), most reads aimed at recent ray ends.
    // ------------------------------------------------------------------
    function automatic olu_beat_t random_beat();
        olu_beat_t b;
        int pick, sx, sy, ex, ey;
        b.mode    = MODE_RAY;
        b.start_x = 16'($urandom);
        b.start_y = 16'($urandom);
        b.end_x   = 16'($urandom);
        b.end_y   = 16'($urandom);
        b.has_hit = 1'($urandom);
        b.cell_x  = 8'($urandom);
        b.cell_y  = 8'($urandom);
        pick      = int'($urandom_range(99));
        if (pick < 2) begin
            b.mode = MODE_NONE;
        end else if (pick < 16) begin
            b.mode = MODE_READ;
            if (pick < 11) begin
                b.cell_x = 8'(last_x);
                b.cell_y = 8'(last_y);
            end
        end else begin
            pick = int'($urandom_range(9));
            if (pick < 7) begin
                sx = int'($urandom_range(40)) - 4;
                sy = int'($urandom_range(40)) - 4;
                ex = int'($urandom_range(40)) - 4;
                ey = int'($urandom_range(40)) - 4;
                if (pick == 6) begin   // degenerate ray, hit rule only
                    ex = sx;
                    ey = sy;
                end
            end else if (pick < 9) begin
                sx = int'($urandom_range(275)) - 10;
                sy = int'($urandom_range(275)) - 10;
                ex = sx + int'($urandom_range(80)) - 40;
                ey = sy + int'($urandom_range(80)) - 40;
            end else begin
                sx = int'($urandom_range(65535)) - 32768;
                sy = int'($urandom_range(65535)) - 32768;
                ex = sat16(sx + int'($urandom_range(60)) - 30);
                ey = sat16(sy + int'($urandom_range(60)) - 30);
            end
            b.start_x = 16'(sx);
            b.start_y = 16'(sy);
            b.end_x   = 16'(ex);
            b.end_y   = 16'(ey);
            if (in_grid(ex, ey)) begin
                last_x = ex;
                last_y = ey;
            end else if (in_grid(sx, sy)) begin
                last_x = sx;
                last_y = sy;
            end
        end
        return b;
    endfunction

    // ------------------------------------------------------------------
    // Input side. Called just after i_clk rises. valid stays high after a
    // beat is taken, ready for the next one; whoever goes quiet next lowers
    // it in that same step.
    // ------------------------------------------------------------------
    task automatic push_item(olu_beat_t b, bit fixed, olu_result_t want);
        olu_result_t r;
        if ($urandom_range(99) < send_gap_pct) begin
            in_ch.valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_gap_pct);
        end
        in_ch.valid   <= 1'b1;
        in_ch.mode    <= b.mode;
        in_ch.start_x <= b.start_x;
        in_ch.start_y <= b.start_y;
        in_ch.end_x   <= b.end_x;
        in_ch.end_y   <= b.end_y;
        in_ch.has_hit <= b.has_hit;
        in_ch.cell_x  <= b.cell_x;
        in_ch.cell_y  <= b.cell_y;
        do @(posedge i_clk); while (in_ch.ready !== 1'b1);
        // beat taken at this edge: model it now, in accept order
        r = advance_grid_model(b);
        pending_results.push_back(fixed ? want : r);
    endtask

    // every item answers with exactly one beat, so an empty queue means idle
    task automatic wait_for_results();
        in_ch.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg_reg sel, int value);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= sel;
        i_cfg_data  <= CFG_DATA_W'(value);
        @(posedge i_clk);
    endtask

    task automatic set_config(int miss, int hit, int lo, int hi);
        wait_for_results();
        write_reg(CFG_MISS_WEIGHT, miss);
        write_reg(CFG_HIT_WEIGHT, hit);
        write_reg(CFG_CLAMP_LOW, lo);
        write_reg(CFG_CLAMP_HIGH, hi);
        i_cfg_we <= 1'b0;
        miss_m = miss;
        hit_m  = hit;
        lo_m   = lo;
        hi_m   = hi;
    endtask

    // ------------------------------------------------------------------
    // Output side: random back-pressure and the in-order check.
    // ------------------------------------------------------------------
    always @(posedge i_clk) rx_ready <= ($urandom_range(99) >= stall_pct);

    always @(posedge i_clk) begin : result_check
        olu_result_t want;
        if (out_ch.valid === 1'b1 && rx_ready) begin
            if (pending_results.size() == 0) begin
                note_failure($sformatf("unexpected result beat: value %0d touched %0d",
                                       out_ch.cell_value, out_ch.cells_touched));
            end else begin
                want = pending_results.pop_front();
                if (out_ch.cell_value !== want.cell_value)
                    note_failure($sformatf("cell_value: expected %0d, got %0d",
                                           want.cell_value, out_ch.cell_value));
                if (out_ch.cells_touched !== want.cells_touched)
                    note_failure($sformatf("cells_touched: expected %0d, got %0d",
                                           want.cells_touched, out_ch.cells_touched));
            end
        end
    end

    // Hard stop. The slowest honest run holds the reset sweep, two clear sweeps
    // in the random part and one in the directed part, one 65k-cell diagonal
    // ray, and ~700 short items with stalls; the limit leaves plenty of margin.
    initial begin : watchdog
        #40_000_000;
        $display("Regression FAIL");
        $finish;
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial begin : stimulus
        dir_row_t  dir_rows [$];
        olu_beat_t beat;
        int phase, k, m, h, lo, hi, t;

        in_ch.valid   <= 1'b0;
        in_ch.mode    <= MODE_NONE;
        in_ch.start_x <= '0;
        in_ch.start_y <= '0;
        in_ch.end_x   <= '0;
        in_ch.end_y   <= '0;
        in_ch.has_hit <= 1'b0;
        in_ch.cell_x  <= '0;
        in_ch.cell_y  <= '0;
        foreach (grid_model[i]) grid_model[i] = '0;

        // Directed rows, default registers (miss -4, hit 9, bounds +/-100)
        dir_rows.push_back(read_row(0, 0, 1, 0));            // grid zero after reset
        dir_rows.push_back(read_row(255, 255, 1, 0));        // far corner
        dir_rows.push_back(cmd_row(MODE_NONE));              // spare code, no effect
        dir_rows.push_back(ray_row(0, 0, 0, 0, 1, 1, 1));    // start == end, hit only
        dir_rows.push_back(read_row(0, 0, 1, 9));
        dir_rows.push_back(ray_row(0, 0, 0, 0, 0, 1, 0));    // start == end, no hit
        dir_rows.push_back(ray_row(0, 0, 10, 0, 1, 1, 11));  // 10 free cells + hit
        dir_rows.push_back(read_row(0, 0, 1, 5));
        dir_rows.push_back(read_row(10, 0, 1, 9));
        // full-range diagonal, crosses the grid corner to corner, end outside
        dir_rows.push_back(ray_row(-32768, -32768, 32767, 32767, 1, 1, 256));
        dir_rows.push_back(read_row(255, 255, 0, 0));
        dir_rows.push_back(ray_row(300, 5, -40, 5, 0, 1, 256));   // leftward row sweep
        dir_rows.push_back(ray_row(5, -20, 5, 260, 1, 1, 256));   // column sweep, end off grid
        dir_rows.push_back(ray_row(3, 7, 40, 19, 1, 0, 0));       // shallow octant
        dir_rows.push_back(ray_row(40, 19, 3, 7, 1, 0, 0));       // same line reversed
        dir_rows.push_back(ray_row(32767, -32768, 32700, -32700, 1, 1, 0)); // all off grid
        dir_rows.push_back(read_row(20, 12, 0, 0));
        dir_rows.push_back(cmd_row(MODE_CLEAR));
        dir_rows.push_back(read_row(5, 100, 1, 0));
        // widest bounds, weights at the extremes: saturate both ways
        dir_rows.push_back(cfg_row(-128, 127, -128, 127));
        dir_rows.push_back(ray_row(50, 50, 50, 50, 1, 1, 1));
        dir_rows.push_back(ray_row(50, 50, 50, 50, 1, 1, 1));
        dir_rows.push_back(read_row(50, 50, 1, 127));
        dir_rows.push_back(ray_row(50, 50, 52, 50, 0, 1, 2));
        dir_rows.push_back(read_row(50, 50, 1, -1));
        dir_rows.push_back(ray_row(50, 50, 51, 50, 0, 1, 1));
        dir_rows.push_back(read_row(50, 50, 1, -128));
        // inverted bounds: every update lands on the low bound
        dir_rows.push_back(cfg_row(-4, 5, 20, -20));
        dir_rows.push_back(ray_row(60, 60, 60, 60, 1, 1, 1));
        dir_rows.push_back(read_row(60, 60, 1, 20));

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[i]) begin
            if (dir_rows[i].is_cfg)
                set_config(dir_rows[i].miss_w, dir_rows[i].hit_w,
                           dir_rows[i].lo_w, dir_rows[i].hi_w);
            else
                push_item(dir_rows[i].beat, dir_rows[i].fixed, dir_rows[i].want);
        end

        // Random part: eight phases, each with its own register setting and one of four
        // back-pressure styles; a clear lands mid-phase twice.
        for (phase = 0; phase < 8; phase++) begin
            case (phase % 4)
                0: begin send_gap_pct = 0;  stall_pct = 0;  end
                1: begin send_gap_pct = 52; stall_pct = 0;  end
                2: begin send_gap_pct = 0;  stall_pct = 52; end
                default: begin send_gap_pct = 9; stall_pct = 9; end
            endcase
            m  = int'($urandom_range(255)) - 128;
            h  = int'($urandom_range(255)) - 128;
            lo = int'($urandom_range(255)) - 128;
            hi = int'($urandom_range(255)) - 128;
            case (phase)
                0: begin
                    m  = int'(MISS_WEIGHT_RST);
                    h  = int'(HIT_WEIGHT_RST);
                    lo = int'(CLAMP_LOW_RST);
                    hi = int'(CLAMP_HIGH_RST);
                end
                2: begin m = -128; h = 127;  lo = -128; hi = 127; end
                4: begin   // inverted pair
                    lo = int'($urandom_range(100));
                    hi = lo - 1 - int'($urandom_range(99));
                end
                5: begin m = 127;  h = -128; lo = -128; hi = 127; end
                6: begin   // small steps, values move slowly
                    m = int'($urandom_range(16)) - 8;
                    h = int'($urandom_range(16)) - 8;
                end
                default: ;
            endcase
            if (phase != 4 && lo > hi) begin
                t  = lo;
                lo = hi;
                hi = t;
            end
            set_config(m, h, lo, hi);

            for (k = 0; k < 88; k++) begin
                beat = random_beat();
                if (k == 44 && (phase == 1 || phase == 5)) beat.mode = MODE_CLEAR;
                push_item(beat, 1'b0, '0);
            end
        end

        wait_for_results();
        // quiet tail: any stray beat shows up as unexpected
        repeat (20) @(posedge i_clk);

        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

### sim.f
design/olu_pkg.sv
design/olu_if.sv
design/olu_ram.sv
design/olu_cell_alu.sv
design/olu_line_step.sv
design/occupancy_ray_log_odds_update.sv
tb/tb_occupancy_ray_log_odds_update.sv
